>>> design/wlcls_pkg.sv
// Package with the item types and constants of the weighted least-cost link selector.
`default_nettype none

package wlcls_pkg;

    typedef struct packed {
        logic [31:0] in_rate;
        logic [31:0] out_rate;
        logic [31:0] max_in_rate;
        logic [31:0] max_out_rate;
        logic [31:0] link_cost;
        logic [31:0] link_mark;
        logic        eligible;
        logic        tie_coin;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] chosen_mark;
        logic [31:0] chosen_weight;
    } out_item_t;

    typedef enum logic [1:0] {
        CFG_SQRT_WEIGHT = 2'd0,
        CFG_LOAD_WEIGHT = 2'd1,
        CFG_COST_WEIGHT = 2'd2,
        CFG_NEWTON      = 2'd3
    } cfg_index_t;

    localparam logic [31:0] NO_WINNER_WEIGHT = 32'h8000_0000;

endpackage

`default_nettype wire

>>> design/weighted_least_cost_link_select.sv
// Top level of the weighted least-cost link selector with its serial arithmetic.
`default_nettype none

// Each input item describes one candidate link. The block works out the link's load (the larger
// of the two rate quotients, all ones where a maximum is zero), an approximate square root of
// load times cost, and the weight wlc*root + wl*load + wc*cost modulo 2^32. The lowest weight of
// an eligible link is kept; a weight equal to the best so far is first nudged by one according
// to tie_coin. On an item with last set the block delivers the best mark and weight (mark 0 and
// weight 2^31 when no link won) and clears its selection for the next connection.
// All arithmetic runs on one bit-serial shift-and-subtract divider and one shift-and-add
// multiplier, one bit per cycle, and the block holds one item at a time. An item passes through
// the two rate divisions and load times cost (a zero maximum cuts its division short), the
// search for the leading one, each Newton step (a square and a division) and the three weight
// products, with a state each to start the products, to settle the selection and to take the
// next item; the reset setting is three Newton steps, and up to seven can be set. A result
// waits in an output register, so the next item is taken while it is still stalled.
module weighted_least_cost_link_select
    import wlcls_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire cfg_index_t cfg_index,
    input  wire logic [9:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_IN,
        S_DIV_OUT,
        S_MUL_LC,
        S_SCAN,
        S_NEWTON,
        S_SQ,
        S_DIVN,
        S_WMUL,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        WP_SQRT,
        WP_LOAD,
        WP_COST
    } wphase_t;

    state_t      state_reg;
    wphase_t     phase_reg;
    in_item_t    item_reg;
    logic [9:0]  sqrt_w_reg;
    logic [9:0]  load_w_reg;
    logic [9:0]  cost_w_reg;
    logic [2:0]  newton_reg;
    logic [2:0]  step_reg;
    logic [31:0] best_w_reg;
    logic [31:0] best_m_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [31:0] lin_reg;
    logic [31:0] load_reg;
    logic [31:0] x_reg;
    logic [31:0] t_reg;
    logic [5:0]  p_reg;
    logic [19:0] a_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;

    // Serial divider: the dividend shifts out of quo_reg while quotient bits shift in.
    logic [31:0] rem_reg;
    logic [39:0] quo_reg;
    logic [31:0] den_reg;
    // Serial multiplier: the multiplicand shifts left, the multiplier shifts right.
    logic [39:0] acc_reg;
    logic [39:0] mc_reg;
    logic [31:0] mp_reg;

    logic [32:0] div_trial;
    logic        div_ge;
    logic [32:0] div_rem;
    logic [31:0] lout;
    logic [31:0] load_sel;
    logic [40:0] sq_diff;
    logic [39:0] sq_mag;
    logic [39:0] a_sum;
    logic [19:0] a_use;
    logic [4:0]  half_p;
    logic [31:0] w_raw;
    logic [31:0] w_adj;
    logic        w_win;
    logic        out_free;

    always_comb
    begin
        div_trial = {rem_reg, quo_reg[39]};
        div_ge    = div_trial >= {1'b0, den_reg};
        div_rem   = div_ge ? (div_trial - {1'b0, den_reg}) : div_trial;

        lout     = (den_reg == 32'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];
        load_sel = (lout >= lin_reg) ? lout : lin_reg;

        // Signed a*a - x; its magnitude is divided and the sign applied afterwards, which
        // gives a quotient truncated toward zero.
        sq_diff = {1'b0, acc_reg} - {9'd0, x_reg};
        sq_mag  = sq_diff[40] ? 40'(-sq_diff) : sq_diff[39:0];
        a_sum   = neg_reg ? ({20'd0, a_reg} + quo_reg) : ({20'd0, a_reg} - quo_reg);
        a_use   = (a_reg == 20'd0) ? 20'd1 : a_reg;
        half_p  = (t_reg == 32'd0) ? 5'd0 : p_reg[5:1];

        w_raw = acc_reg[31:0];
        if (w_raw == best_w_reg)
        begin
            w_adj = item_reg.tie_coin ? (w_raw + 32'd1) : (w_raw - 32'd1);
        end
        else
        begin
            w_adj = w_raw;
        end
        w_win    = item_reg.eligible && (w_adj < best_w_reg);
        out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= WP_SQRT;
            sqrt_w_reg    <= 10'd10;
            load_w_reg    <= 10'd1;
            cost_w_reg    <= 10'd5;
            newton_reg    <= 3'd3;
            step_reg      <= 3'd0;
            best_w_reg    <= NO_WINNER_WEIGHT;
            best_m_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
        end
        else
        begin
            // A result leaves unless a new one replaces it in the same cycle.
            if (out_valid_reg && !out_stall && !(state_reg == S_FIN && item_reg.last))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SQRT_WEIGHT: sqrt_w_reg <= cfg_data;
                    CFG_LOAD_WEIGHT: load_w_reg <= cfg_data;
                    CFG_COST_WEIGHT: cost_w_reg <= cfg_data;
                    CFG_NEWTON:      newton_reg <= cfg_data[2:0];
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_item;
                        quo_reg   <= {8'd0, in_item.in_rate};
                        den_reg   <= in_item.max_in_rate;
                        rem_reg   <= 32'd0;
                        cnt_reg   <= 6'd40;
                        state_reg <= S_DIV_IN;
                    end
                end

                S_DIV_IN, S_DIV_OUT, S_DIVN:
                begin
                    if (cnt_reg != 6'd0 && den_reg != 32'd0)
                    begin
                        rem_reg <= div_rem[31:0];
                        quo_reg <= {quo_reg[38:0], div_ge};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                    else if (state_reg == S_DIV_IN)
                    begin
                        lin_reg   <= lout;
                        quo_reg   <= {8'd0, item_reg.out_rate};
                        den_reg   <= item_reg.max_out_rate;
                        rem_reg   <= 32'd0;
                        cnt_reg   <= 6'd40;
                        state_reg <= S_DIV_OUT;
                    end
                    else if (state_reg == S_DIV_OUT)
                    begin
                        load_reg  <= load_sel;
                        mc_reg    <= {8'd0, load_sel};
                        mp_reg    <= item_reg.link_cost;
                        acc_reg   <= 40'd0;
                        cnt_reg   <= 6'd32;
                        state_reg <= S_MUL_LC;
                    end
                    else
                    begin
                        a_reg     <= a_sum[19:0];
                        step_reg  <= step_reg - 3'd1;
                        state_reg <= S_NEWTON;
                    end
                end

                S_MUL_LC, S_SQ, S_WMUL:
                begin
                    if (cnt_reg != 6'd0)
                    begin
                        if (mp_reg[0])
                        begin
                            acc_reg <= acc_reg + mc_reg;
                        end
                        mc_reg  <= {mc_reg[38:0], 1'b0};
                        mp_reg  <= {1'b0, mp_reg[31:1]};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                    else if (state_reg == S_MUL_LC)
                    begin
                        x_reg     <= acc_reg[31:0];
                        t_reg     <= acc_reg[31:0];
                        p_reg     <= 6'd32;
                        state_reg <= S_SCAN;
                    end
                    else if (state_reg == S_SQ)
                    begin
                        neg_reg   <= sq_diff[40];
                        quo_reg   <= sq_mag;
                        den_reg   <= {11'd0, a_reg, 1'b0};
                        rem_reg   <= 32'd0;
                        cnt_reg   <= 6'd40;
                        state_reg <= S_DIVN;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            WP_SQRT:
                            begin
                                mc_reg    <= {8'd0, load_reg};
                                mp_reg    <= {22'd0, load_w_reg};
                                cnt_reg   <= 6'd10;
                                phase_reg <= WP_LOAD;
                            end
                            WP_LOAD:
                            begin
                                mc_reg    <= {8'd0, item_reg.link_cost};
                                mp_reg    <= {22'd0, cost_w_reg};
                                cnt_reg   <= 6'd10;
                                phase_reg <= WP_COST;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    // Walk to the leading one of x; p ends as its 1-based position.
                    if (t_reg == 32'd0 || t_reg[31])
                    begin
                        a_reg     <= 20'd1 << half_p;
                        step_reg  <= newton_reg;
                        state_reg <= S_NEWTON;
                    end
                    else
                    begin
                        t_reg <= {t_reg[30:0], 1'b0};
                        p_reg <= p_reg - 6'd1;
                    end
                end

                S_NEWTON:
                begin
                    if (step_reg == 3'd0)
                    begin
                        acc_reg   <= 40'd0;
                        mc_reg    <= {20'd0, a_reg};
                        mp_reg    <= {22'd0, sqrt_w_reg};
                        cnt_reg   <= 6'd10;
                        phase_reg <= WP_SQRT;
                        state_reg <= S_WMUL;
                    end
                    else
                    begin
                        a_reg     <= a_use;
                        mc_reg    <= {20'd0, a_use};
                        mp_reg    <= {12'd0, a_use};
                        acc_reg   <= 40'd0;
                        cnt_reg   <= 6'd20;
                        state_reg <= S_SQ;
                    end
                end

                S_FIN:
                begin
                    if (!item_reg.last)
                    begin
                        if (w_win)
                        begin
                            best_w_reg <= w_adj;
                            best_m_reg <= item_reg.link_mark;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg.chosen_mark   <= w_win ? item_reg.link_mark : best_m_reg;
                        out_reg.chosen_weight <= w_win ? w_adj : best_w_reg;
                        out_valid_reg         <= 1'b1;
                        best_w_reg            <= NO_WINNER_WEIGHT;
                        best_m_reg            <= 32'd0;
                        state_reg             <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> design/wlcls_checker.sv
// Port-level checker of the weighted least-cost link selector and its bind.
`default_nettype none

module wlcls_checker
    import wlcls_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // A winning weight is always below the no-winner value.
    a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.chosen_weight <= NO_WINNER_WEIGHT)
        else $error("chosen weight above the no-winner value");

    // Without a winner the mark is zero.
    a_no_winner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.chosen_weight == NO_WINNER_WEIGHT
            |-> out_item.chosen_mark == 32'd0)
        else $error("no-winner result with a nonzero mark");

endmodule

bind weighted_least_cost_link_select wlcls_checker u_wlcls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
